FILE: rtl/uadp_pkg.sv
// Types and constants shared by the USB audio descriptor parser.
// No dependencies; compile first.
package uadp_pkg;

  // Descriptor type codes
  localparam logic [7:0] DT_INTERFACE    = 8'h04;
  localparam logic [7:0] DT_ENDPOINT     = 8'h05;
  localparam logic [7:0] DT_CS_INTERFACE = 8'h24;

  // Class-specific subtypes and codes
  localparam logic [7:0] AS_SUB_GENERAL     = 8'h01;
  localparam logic [7:0] AS_FORMAT_TYPE     = 8'h02;
  localparam logic [7:0] FORMAT_TYPE_I      = 8'h01;
  localparam logic [7:0] SUBCLASS_STREAMING = 8'h02;
  localparam logic [7:0] PROTOCOL_UAC2      = 8'h20;
  localparam logic [1:0] XFER_ISO           = 2'b01;

  localparam logic [23:0] DEFAULT_RATE = 24'd48000;
  localparam logic [3:0]  MIN_CONFIG   = 4'd9;

  // Highest descriptor byte that decoding ever looks at
  localparam int RD_LAST = 10;

  // Result queue depth
  localparam int QUEUE_DEPTH = 4;

  // Result kinds
  localparam logic [1:0] KIND_CAPTURE  = 2'd0;
  localparam logic [1:0] KIND_PLAYBACK = 2'd1;
  localparam logic [1:0] KIND_SUMMARY  = 2'd2;
  localparam logic [1:0] KIND_SUM_BAD  = 2'd3;

  // Version codes
  localparam logic [1:0] VER_UNKNOWN = 2'd0;
  localparam logic [1:0] VER_UAC1    = 2'd1;
  localparam logic [1:0] VER_UAC2    = 2'd2;

  typedef struct packed {
    logic [7:0]  ch;
    logic [7:0]  sub;
    logic [7:0]  bits;
    logic [23:0] rate;
    logic        valid;
  } fmt_t;

  typedef struct packed {
    logic [7:0]  addr;
    logic [15:0] mps;
    logic        is_in;
  } ep_t;

  typedef struct packed {
    logic [1:0]  entry_kind;
    logic [7:0]  if_num;
    logic [7:0]  alt_setting;
    logic [7:0]  ep_addr;
    logic [15:0] packet_max;
    logic [7:0]  channel_count;
    logic [7:0]  subframe_size;
    logic [7:0]  sample_bits;
    logic [23:0] sample_rate;
    logic [1:0]  class_rev;
    logic        found_any;
    logic        run_last;
  } res_t;

endpackage

FILE: rtl/uadp_if.sv
// Channel interfaces of the USB audio descriptor parser: byte input and result output.
// Valid/ready handshake; no dependencies.
interface uadp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_config;

  modport source(output valid, byte_value, end_of_config, input ready);
  modport sink(input valid, byte_value, end_of_config, output ready);
endinterface

interface uadp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  entry_kind;
  logic [7:0]  if_num;
  logic [7:0]  alt_setting;
  logic [7:0]  ep_addr;
  logic [15:0] packet_max;
  logic [7:0]  channel_count;
  logic [7:0]  subframe_size;
  logic [7:0]  sample_bits;
  logic [23:0] sample_rate;
  logic [1:0]  class_rev;
  logic        found_any;
  logic        run_last;

  modport source(output valid, entry_kind, if_num, alt_setting, ep_addr,
                 packet_max, channel_count, subframe_size, sample_bits,
                 sample_rate, class_rev, found_any, run_last,
                 input ready);
  modport sink(input valid, entry_kind, if_num, alt_setting, ep_addr,
               packet_max, channel_count, subframe_size, sample_bits,
               sample_rate, class_rev, found_any, run_last,
               output ready);
endinterface

FILE: rtl/uadp_parse_core.sv
// Parser state and per-byte decode: descriptor collection, interface and format
// tracking, entry commit and summary. Depends on uadp_pkg.
module uadp_parse_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [7:0]      byte_in,
  input  logic            eoc_in,
  output logic [1:0]      res_cnt,
  output uadp_pkg::res_t  res0,
  output uadp_pkg::res_t  res1
);
  import uadp_pkg::*;

  // Descriptor collection
  logic [7:0] idx_r, idx_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] dbuf_r   [1:RD_LAST];
  logic [7:0] dbuf_nxt [1:RD_LAST];
  logic [7:0] rd       [1:RD_LAST];

  // Interface and stream state
  logic [7:0] alt_r, alt_nxt;
  logic [7:0] sub_r, sub_nxt;
  logic [7:0] proto_r, proto_nxt;
  fmt_t       ifmt_r, ifmt_nxt;
  fmt_t       pfmt_r, pfmt_nxt;
  logic [7:0] pifn_r, pifn_nxt;
  logic [7:0] palt_r, palt_nxt;
  ep_t        pep_r, pep_nxt;
  logic [1:0] ver_r, ver_nxt;
  logic       any_r, any_nxt;
  logic       halt_r, halt_nxt;
  logic [3:0] tc_r, tc_nxt;

  // Decode scratch
  logic       do_proc;
  logic       cm_go;
  fmt_t       cm_fmt;
  ep_t        cm_ep;
  fmt_t       f;
  logic       ok;
  logic       t1;
  logic       entry_v;
  res_t       entry;
  res_t       sum;

  // Read a collected byte; bytes past the descriptor length read as zero
  always_comb begin
    for (int i = 1; i <= RD_LAST; i++) begin
      if (8'(i) < len_r) begin
        rd[i] = (8'(i) == idx_r) ? byte_in : dbuf_r[i];
      end else begin
        rd[i] = '0;
      end
    end
  end

  always_comb begin
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    dbuf_nxt  = dbuf_r;
    alt_nxt   = alt_r;
    sub_nxt   = sub_r;
    proto_nxt = proto_r;
    ifmt_nxt  = ifmt_r;
    pfmt_nxt  = pfmt_r;
    pifn_nxt  = pifn_r;
    palt_nxt  = palt_r;
    pep_nxt   = pep_r;
    ver_nxt   = ver_r;
    any_nxt   = any_r;
    halt_nxt  = halt_r;
    tc_nxt    = (tc_r < MIN_CONFIG) ? tc_r + 4'd1 : tc_r;
    do_proc   = 1'b0;
    cm_go     = 1'b0;
    cm_fmt    = pfmt_r;
    cm_ep     = pep_r;
    f         = pfmt_r;
    ok        = 1'b0;
    t1        = 1'b0;
    entry_v   = 1'b0;
    entry     = '0;
    sum       = '0;

    // Collect the byte into the current descriptor
    if (!halt_r) begin
      if (idx_r == 8'd0) begin
        if (!eoc_in) begin
          if (byte_in < 8'd2) begin
            halt_nxt = 1'b1;
          end else begin
            len_nxt = byte_in;
            idx_nxt = 8'd1;
          end
        end
      end else begin
        for (int i = 1; i <= RD_LAST; i++) begin
          if (idx_r == 8'(i)) dbuf_nxt[i] = byte_in;
        end
        idx_nxt = idx_r + 8'd1;
        if (idx_nxt == len_r) begin
          do_proc = 1'b1;
          idx_nxt = 8'd0;
        end else if (eoc_in) begin
          halt_nxt = 1'b1;
        end
      end
    end

    // Decode a completed descriptor
    if (do_proc) begin
      if (rd[1] == DT_INTERFACE) begin
        // recommit the pending entry of the previous streaming interface
        cm_go     = (sub_r == SUBCLASS_STREAMING) && (alt_r != 8'd0);
        cm_fmt    = pfmt_r;
        cm_ep     = pep_r;
        pep_nxt   = '0;
        alt_nxt   = rd[3];
        sub_nxt   = rd[6];
        proto_nxt = rd[7];
        ifmt_nxt  = '0;
        pfmt_nxt  = '0;
        pifn_nxt  = rd[2];
        palt_nxt  = rd[3];
      end else if (rd[1] == DT_CS_INTERFACE && sub_r == SUBCLASS_STREAMING) begin
        if (rd[2] == AS_SUB_GENERAL) begin
          if (len_r >= 8'd16 && proto_r == PROTOCOL_UAC2) begin
            f.ch    = rd[10];
            f.valid = (rd[10] != 8'd0);
            ok      = f.valid;
          end
        end else if (rd[2] == AS_FORMAT_TYPE) begin
          if (len_r >= 8'd6 && rd[3] == FORMAT_TYPE_I) begin
            if (len_r == 8'd6) begin
              f.sub  = rd[4];
              f.bits = rd[5];
              t1     = 1'b1;
            end else if (len_r >= 8'd8) begin
              f.ch   = rd[4];
              f.sub  = rd[5];
              f.bits = rd[6];
              if (len_r >= 8'd11) f.rate = {rd[10], rd[9], rd[8]};
              t1     = 1'b1;
            end
            if (t1) begin
              if (f.rate == 24'd0) f.rate = DEFAULT_RATE;
              f.valid = (f.ch != 8'd0) && (f.sub != 8'd0);
              ok      = f.valid;
            end
          end
        end
        if (ok) begin
          ifmt_nxt = f;
          pfmt_nxt = f;
        end
      end else if (rd[1] == DT_ENDPOINT && sub_r == SUBCLASS_STREAMING &&
                   alt_r != 8'd0) begin
        if (rd[3][1:0] == XFER_ISO) begin
          cm_ep.addr  = rd[2];
          cm_ep.mps   = {rd[5], rd[4]};
          cm_ep.is_in = rd[2][7];
          cm_fmt      = ifmt_r;
          cm_go       = 1'b1;
          pep_nxt     = cm_ep;
          pfmt_nxt    = ifmt_r;
        end
      end
    end

    // Commit an entry when format and endpoint are usable
    if (cm_go && cm_fmt.valid && cm_ep.addr != 8'd0) begin
      entry_v = 1'b1;
      any_nxt = 1'b1;
      if (ver_r == VER_UNKNOWN) begin
        ver_nxt = (proto_r == PROTOCOL_UAC2) ? VER_UAC2 : VER_UAC1;
      end
      entry.entry_kind    = cm_ep.is_in ? KIND_CAPTURE : KIND_PLAYBACK;
      entry.if_num        = pifn_r;
      entry.alt_setting   = palt_r;
      entry.ep_addr       = cm_ep.addr;
      entry.packet_max    = cm_ep.mps;
      entry.channel_count = cm_fmt.ch;
      entry.subframe_size = cm_fmt.sub;
      entry.sample_bits   = cm_fmt.bits;
      entry.sample_rate   = cm_fmt.rate;
      entry.class_rev     = ver_nxt;
      entry.found_any     = 1'b0;
      entry.run_last      = !eoc_in;
    end

    // Summary on the last byte, then return to reset
    if (eoc_in) begin
      sum.run_last = 1'b1;
      if (tc_nxt < MIN_CONFIG) begin
        sum.entry_kind = KIND_SUMMARY;
      end else begin
        sum.entry_kind = halt_nxt ? KIND_SUM_BAD : KIND_SUMMARY;
        sum.class_rev  = ver_nxt;
        sum.found_any  = any_nxt;
      end
      idx_nxt   = '0;
      len_nxt   = '0;
      alt_nxt   = '0;
      sub_nxt   = '0;
      proto_nxt = '0;
      ifmt_nxt  = '0;
      pfmt_nxt  = '0;
      pifn_nxt  = '0;
      palt_nxt  = '0;
      pep_nxt   = '0;
      ver_nxt   = VER_UNKNOWN;
      any_nxt   = 1'b0;
      halt_nxt  = 1'b0;
      tc_nxt    = '0;
    end
  end

  // Pack the results of this byte, entry first
  always_comb begin
    res_cnt = {1'b0, entry_v} + {1'b0, eoc_in};
    res0    = entry_v ? entry : sum;
    res1    = sum;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      len_r   <= '0;
      alt_r   <= '0;
      sub_r   <= '0;
      proto_r <= '0;
      ifmt_r  <= '0;
      pfmt_r  <= '0;
      pifn_r  <= '0;
      palt_r  <= '0;
      pep_r   <= '0;
      ver_r   <= VER_UNKNOWN;
      any_r   <= 1'b0;
      halt_r  <= 1'b0;
      tc_r    <= '0;
    end else if (fire) begin
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      alt_r   <= alt_nxt;
      sub_r   <= sub_nxt;
      proto_r <= proto_nxt;
      ifmt_r  <= ifmt_nxt;
      pfmt_r  <= pfmt_nxt;
      pifn_r  <= pifn_nxt;
      palt_r  <= palt_nxt;
      pep_r   <= pep_nxt;
      ver_r   <= ver_nxt;
      any_r   <= any_nxt;
      halt_r  <= halt_nxt;
      tc_r    <= tc_nxt;
    end
  end

  // Descriptor bytes; always written before they are read
  always_ff @(posedge clk) begin
    if (fire) dbuf_r <= dbuf_nxt;
  end

endmodule

FILE: rtl/uadp_result_queue.sv
// Small result queue: takes up to two results per cycle, delivers one per cycle while the receiver is ready.
// Depends on uadp_pkg and uadp_out_if.
module uadp_result_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_cnt,
  input  uadp_pkg::res_t  push0,
  input  uadp_pkg::res_t  push1,
  output logic            space_ok,
  uadp_out_if.source      out_ch
);
  import uadp_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  res_t          q_r   [QUEUE_DEPTH];
  res_t          q_nxt [QUEUE_DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] base;
  logic          pop;

  assign pop      = out_ch.valid && out_ch.ready;
  assign space_ok = (cnt_r <= CW'(QUEUE_DEPTH - 2));

  // Shift out the head, append new results behind the survivors
  always_comb begin
    base = cnt_r - CW'(pop);
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (pop && j < QUEUE_DEPTH - 1) begin
        q_nxt[j] = q_r[j + 1];
      end else begin
        q_nxt[j] = q_r[j];
      end
      if (push_cnt != 2'd0 && CW'(j) == base) q_nxt[j] = push0;
      if (push_cnt == 2'd2 && CW'(j) == base + CW'(1)) q_nxt[j] = push1;
    end
    cnt_nxt = base + CW'(push_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // Drive the head item
  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.entry_kind    = q_r[0].entry_kind;
  assign out_ch.if_num        = q_r[0].if_num;
  assign out_ch.alt_setting   = q_r[0].alt_setting;
  assign out_ch.ep_addr       = q_r[0].ep_addr;
  assign out_ch.packet_max    = q_r[0].packet_max;
  assign out_ch.channel_count = q_r[0].channel_count;
  assign out_ch.subframe_size = q_r[0].subframe_size;
  assign out_ch.sample_bits   = q_r[0].sample_bits;
  assign out_ch.sample_rate   = q_r[0].sample_rate;
  assign out_ch.class_rev     = q_r[0].class_rev;
  assign out_ch.found_any     = q_r[0].found_any;
  assign out_ch.run_last      = q_r[0].run_last;

endmodule

FILE: rtl/usb_audio_descriptor_parser.sv
// Top level of the USB audio configuration descriptor parser.
// Depends on uadp_pkg, uadp_if, uadp_parse_core and uadp_result_queue.

// Takes a configuration descriptor one byte per item and reports one capture or
// playback entry per usable isochronous audio endpoint, plus a summary on the byte
// flagged end_of_config. Sustained rate is one byte per cycle. A byte is held in an
// input register and decoded once the result queue has room for two results; its
// results (at most two: an entry and a summary) then land in a four-deep result
// queue, from whose head they are taken. The queue drains one result per cycle
// while the receiver is ready, so input stalls only while more than two results
// wait to be taken. After the summary the parser returns to its reset state for
// the next configuration.
module usb_audio_descriptor_parser (
  input  logic        clk,
  input  logic        rst_n,
  uadp_in_if.sink     in_ch,
  uadp_out_if.source  out_ch
);
  import uadp_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_eoc_r;
  logic       in_acc;
  logic       proc_fire;
  logic       space_ok;
  logic [1:0] res_cnt;
  res_t       res0;
  res_t       res1;

  // Decode the held byte when the queue can take two results
  assign proc_fire   = in_vld_r && space_ok;
  assign in_ch.ready = !in_vld_r || proc_fire;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (proc_fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_ch.byte_value;
      in_eoc_r  <= in_ch.end_of_config;
    end
  end

  uadp_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (proc_fire),
    .byte_in (in_byte_r),
    .eoc_in  (in_eoc_r),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  uadp_result_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (proc_fire ? res_cnt : 2'd0),
    .push0    (res0),
    .push1    (res1),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

FILE: tb/uadp_tb_pkg.sv
// Scoreboard for the USB audio descriptor parser testbench: a byte-level
// model of the parser and the queue of results that it expects.
// Depends on uadp_pkg.
package uadp_tb_pkg;
  import uadp_pkg::*;

  // Descriptor buffer depth of the model
  localparam int BUF_BYTES = 16;
  // Mismatches shown in full; later ones are only counted
  localparam int SHOW_LIMIT = 10;

  class entry_scoreboard;
    res_t expected_entries[$];
    res_t burst[$];
    int unsigned errors;
    int unsigned results_seen;

    // Parser state
    logic [7:0]  byte_idx;
    logic [7:0]  desc_size;
    logic [7:0]  desc_buf [BUF_BYTES];
    logic [7:0]  alt_cur;
    logic [7:0]  subclass_cur;
    logic [7:0]  protocol_cur;
    fmt_t        fmt_cur;
    fmt_t        fmt_pending;
    logic [15:0] ids_pending;
    ep_t         ep_pending;
    logic [1:0]  version;
    bit          any_entry;
    bit          halted;
    int unsigned bytes_seen;

    function new();
      errors = 0;
      results_seen = 0;
      clear_state();
    endfunction

    function void clear_state();
      byte_idx = '0;
      desc_size = '0;
      foreach (desc_buf[i]) desc_buf[i] = '0;
      alt_cur = '0;
      subclass_cur = '0;
      protocol_cur = '0;
      fmt_cur = '0;
      fmt_pending = '0;
      ids_pending = '0;
      ep_pending = '0;
      version = VER_UNKNOWN;
      any_entry = 1'b0;
      halted = 1'b0;
      bytes_seen = 0;
    endfunction

    // Bytes past the descriptor length or the buffer read as zero
    function logic [7:0] held_byte(int unsigned i);
      return (i < BUF_BYTES && i < desc_size) ? desc_buf[i] : 8'h00;
    endfunction

    // Emit the pending entry if it has a valid format and a live endpoint
    function void commit_entry();
      res_t r;
      if (!fmt_pending.valid || ep_pending.addr == 8'h00) return;
      if (version == VER_UNKNOWN)
        version = (protocol_cur == PROTOCOL_UAC2) ? VER_UAC2 : VER_UAC1;
      any_entry = 1'b1;
      r = '0;
      r.entry_kind = ep_pending.is_in ? KIND_CAPTURE : KIND_PLAYBACK;
      r.if_num = ids_pending[15:8];
      r.alt_setting = ids_pending[7:0];
      r.ep_addr = ep_pending.addr;
      r.packet_max = ep_pending.mps;
      r.channel_count = fmt_pending.ch;
      r.subframe_size = fmt_pending.sub;
      r.sample_bits = fmt_pending.bits;
      r.sample_rate = fmt_pending.rate;
      r.class_rev = version;
      burst.insert(burst.size(), r);
    endfunction

    // Decode a complete descriptor
    function void decode_descriptor();
      fmt_t       f;
      bit         ok;
      logic [7:0] kind;
      logic [7:0] addr;
      logic [7:0] attr;
      kind = held_byte(1);
      if (kind == DT_INTERFACE) begin
        if (subclass_cur == SUBCLASS_STREAMING && alt_cur != 8'h00) commit_entry();
        ep_pending = '0;
        alt_cur = held_byte(3);
        subclass_cur = held_byte(6);
        protocol_cur = held_byte(7);
        fmt_cur = '0;
        fmt_pending = '0;
        ids_pending = {held_byte(2), alt_cur};
      end else if (kind == DT_CS_INTERFACE && subclass_cur == SUBCLASS_STREAMING) begin
        f = fmt_pending;
        ok = 1'b0;
        if (held_byte(2) == AS_SUB_GENERAL) begin
          // Only the UAC2 general descriptor carries a channel count
          if (protocol_cur == PROTOCOL_UAC2 && desc_size >= 16) begin
            f.ch = held_byte(10);
            f.valid = (f.ch != 8'h00);
            ok = f.valid;
          end
        end else if (held_byte(2) == AS_FORMAT_TYPE && desc_size >= 6 &&
                     held_byte(3) == FORMAT_TYPE_I && desc_size != 7) begin
          if (desc_size == 6) begin
            f.sub = held_byte(4);
            f.bits = held_byte(5);
          end else begin
            f.ch = held_byte(4);
            f.sub = held_byte(5);
            f.bits = held_byte(6);
            if (desc_size >= 11) f.rate = {held_byte(10), held_byte(9), held_byte(8)};
          end
          if (f.rate == 24'd0) f.rate = DEFAULT_RATE;
          f.valid = (f.ch != 8'h00) && (f.sub != 8'h00);
          ok = f.valid;
        end
        if (ok) begin
          fmt_cur = f;
          fmt_pending = f;
        end
      end else if (kind == DT_ENDPOINT && subclass_cur == SUBCLASS_STREAMING &&
                   alt_cur != 8'h00) begin
        addr = held_byte(2);
        attr = held_byte(3);
        if (attr[1:0] == XFER_ISO) begin
          ep_pending.addr = addr;
          ep_pending.mps = {held_byte(5), held_byte(4)};
          ep_pending.is_in = addr[7];
          fmt_pending = fmt_cur;
          commit_entry();
        end
      end
    endfunction

    // Advance the model by one accepted byte and queue the results it causes
    function void note_byte(logic [7:0] b, logic eoc);
      res_t r;
      burst.delete();
      if (bytes_seen < MIN_CONFIG) bytes_seen++;
      if (!halted) begin
        if (byte_idx == 8'd0) begin
          if (!eoc) begin
            if (b < 8'd2) begin
              halted = 1'b1;
            end else begin
              foreach (desc_buf[i]) desc_buf[i] = '0;
              desc_buf[0] = b;
              desc_size = b;
              byte_idx = 8'd1;
            end
          end
        end else begin
          if (byte_idx < BUF_BYTES) desc_buf[byte_idx] = b;
          byte_idx++;
          if (byte_idx == desc_size) begin
            decode_descriptor();
            byte_idx = 8'd0;
          end else if (eoc) begin
            halted = 1'b1;
          end
        end
      end
      if (eoc) begin
        r = '0;
        if (bytes_seen < MIN_CONFIG) begin
          r.entry_kind = KIND_SUMMARY;
        end else begin
          r.entry_kind = halted ? KIND_SUM_BAD : KIND_SUMMARY;
          r.class_rev = version;
          r.found_any = any_entry;
        end
        burst.insert(burst.size(), r);
        clear_state();
      end
      if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
      foreach (burst[i]) expected_entries.insert(expected_entries.size(), burst[i]);
    endfunction

    function int waiting();
      return expected_entries.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= SHOW_LIMIT) $display("%s", msg);
    endfunction

    // Compare one result with the oldest expectation
    function void check_entry(res_t got);
      res_t  want;
      string bad;
      results_seen++;
      if (expected_entries.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected: %p", results_seen, got));
        return;
      end
      want = expected_entries.pop_front();
      bad = "";
      if (got.entry_kind !== want.entry_kind) bad = {bad, " entry_kind"};
      if (got.if_num !== want.if_num) bad = {bad, " if_num"};
      if (got.alt_setting !== want.alt_setting) bad = {bad, " alt_setting"};
      if (got.ep_addr !== want.ep_addr) bad = {bad, " ep_addr"};
      if (got.packet_max !== want.packet_max) bad = {bad, " packet_max"};
      if (got.channel_count !== want.channel_count) bad = {bad, " channel_count"};
      if (got.subframe_size !== want.subframe_size) bad = {bad, " subframe_size"};
      if (got.sample_bits !== want.sample_bits) bad = {bad, " sample_bits"};
      if (got.sample_rate !== want.sample_rate) bad = {bad, " sample_rate"};
      if (got.class_rev !== want.class_rev) bad = {bad, " class_rev"};
      if (got.found_any !== want.found_any) bad = {bad, " found_any"};
      if (got.run_last !== want.run_last) bad = {bad, " run_last"};
      if (bad != "")
        report($sformatf("result %0d differs in%s: expected %p, got %p",
                         results_seen, bad, want, got));
    endfunction
  endclass

endpackage

FILE: tb/tb_usb_audio_descriptor_parser.sv
// Testbench for usb_audio_descriptor_parser: streams random configuration
// descriptors through the byte channel and checks every result against a model.
// Depends on uadp_pkg, uadp_if, uadp_tb_pkg and the parser RTL.
module tb_usb_audio_descriptor_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import uadp_pkg::*;
  import uadp_tb_pkg::*;

  localparam logic [7:0] DT_CONFIG   = 8'h02;
  localparam logic [7:0] CLASS_AUDIO = 8'h01;

  // Idling phases
  localparam int PH_SEND_IDLE = 0;
  localparam int PH_RECV_IDLE = 1;
  localparam int PH_FREE      = 2;

  localparam int unsigned ITEM_GOAL = 1300;
  localparam int SQUEEZE_CYCLES     = 300;

  logic clk = 1'b0;
  logic rst_n;

  uadp_in_if  in_ch();
  uadp_out_if out_ch();

  usb_audio_descriptor_parser DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  entry_scoreboard board;

  logic [7:0]  cfg_q[$];
  int          desc_start;
  int          desc_want;
  int unsigned items_sent = 0;
  int          phase = PH_SEND_IDLE;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;
  int          squeeze_left = 0;

  always #5 clk = ~clk;

  // Random byte weighted toward the extremes
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_count();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [7:0] pick_size();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return rand_byte();
      default: return 8'($urandom_range(2, 4));
    endcase
  endfunction

  // Append one byte to the configuration being built
  function automatic void put_byte(logic [7:0] b);
    cfg_q.insert(cfg_q.size(), b);
  endfunction

  // Start a descriptor of the given length; close_desc trims or pads it
  function automatic void open_desc(int len, logic [7:0] kind);
    desc_start = cfg_q.size();
    desc_want = len;
    put_byte(8'(len));
    put_byte(kind);
  endfunction

  function automatic void close_desc();
    while (cfg_q.size() > desc_start + desc_want) void'(cfg_q.pop_back());
    while (cfg_q.size() < desc_start + desc_want) put_byte(rand_byte());
  endfunction

  function automatic void add_iface(logic [7:0] ifn, logic [7:0] alt,
                                    logic [7:0] subclass, logic [7:0] protocol);
    open_desc(($urandom_range(15) == 0) ? $urandom_range(2, 12) : 9, DT_INTERFACE);
    put_byte(ifn);
    put_byte(alt);
    put_byte(8'($urandom_range(2)));
    put_byte(CLASS_AUDIO);
    put_byte(subclass);
    put_byte(protocol);
    close_desc();
  endfunction

  function automatic void add_general();
    open_desc(($urandom_range(4) == 0) ? $urandom_range(3, 20) : 16, DT_CS_INTERFACE);
    put_byte(($urandom_range(9) == 0) ? rand_byte() : AS_SUB_GENERAL);
    repeat (7) put_byte(rand_byte());
    put_byte(pick_count());
    close_desc();
  endfunction

  function automatic void add_format(bit uac2);
    int          len;
    logic [23:0] rate;
    case ($urandom_range(9))
      0: len = $urandom_range(2, 20);
      1: len = 7;
      2: len = 8;
      3: len = 14;
      default: len = uac2 ? 6 : 11;
    endcase
    case ($urandom_range(6))
      0: rate = 24'd44100;
      1: rate = 24'd96000;
      2: rate = 24'd0;
      3: rate = 24'hFFFFFF;
      4: rate = 24'($urandom);
      default: rate = DEFAULT_RATE;
    endcase
    open_desc(len, DT_CS_INTERFACE);
    put_byte(($urandom_range(11) == 0) ? rand_byte() : AS_FORMAT_TYPE);
    put_byte(($urandom_range(11) == 0) ? rand_byte() : FORMAT_TYPE_I);
    if (len == 6) begin
      put_byte(pick_size());
      put_byte(rand_byte());
    end else begin
      put_byte(pick_count());
      put_byte(pick_size());
      put_byte(rand_byte());
      put_byte(8'h01);
      put_byte(rate[7:0]);
      put_byte(rate[15:8]);
      put_byte(rate[23:16]);
    end
    close_desc();
  endfunction

  function automatic void add_endpoint();
    int          len;
    logic [7:0]  addr;
    logic [7:0]  attr;
    logic [15:0] mps;
    case ($urandom_range(9))
      0: len = $urandom_range(2, 6);
      1, 2: len = 9;
      default: len = 7;
    endcase
    addr = ($urandom_range(9) == 0) ? rand_byte() :
           {1'($urandom_range(1)), 3'b000, 4'($urandom_range(15))};
    case ($urandom_range(7))
      0: attr = rand_byte();
      1: attr = 8'h02;
      2: attr = 8'h0D;
      3: attr = 8'h25;
      default: attr = 8'h05;
    endcase
    case ($urandom_range(7))
      0: mps = 16'hFFFF;
      1: mps = 16'h0000;
      2: mps = 16'($urandom);
      default: mps = 16'($urandom_range(1, 1024));
    endcase
    open_desc(len, DT_ENDPOINT);
    put_byte(addr);
    put_byte(attr);
    put_byte(mps[7:0]);
    put_byte(mps[15:8]);
    close_desc();
  endfunction

  // One configuration: mostly well formed, some short, broken or cut off
  function automatic void build_config();
    int          mode;
    int          n_if;
    int          n_alt;
    int          bad_at;
    int          k;
    int          cut;
    bit          uac2;
    logic [7:0]  ifn;
    logic [7:0]  subclass;
    logic [7:0]  protocol;
    cfg_q.delete();
    mode = $urandom_range(99);
    if (mode < 4) begin
      repeat ($urandom_range(1, 8)) put_byte(rand_byte());
      return;
    end
    open_desc(9, DT_CONFIG);
    repeat (7) put_byte(rand_byte());
    close_desc();
    n_if = $urandom_range(1, 3);
    bad_at = (mode < 10) ? $urandom_range(0, n_if - 1) : n_if;
    for (k = 0; k < n_if; k++) begin
      if (k == bad_at) put_byte(8'($urandom_range(1)));
      ifn = ($urandom_range(7) == 0) ? rand_byte() : 8'($urandom_range(3));
      uac2 = 1'($urandom_range(1));
      protocol = uac2 ? PROTOCOL_UAC2 : (($urandom_range(7) == 0) ? rand_byte() : 8'h00);
      subclass = ($urandom_range(9) == 0) ? rand_byte() : SUBCLASS_STREAMING;
      if ($urandom_range(1)) add_iface(ifn, 8'h00, subclass, protocol);
      n_alt = $urandom_range(1, 2);
      repeat (n_alt) begin
        add_iface(ifn, ($urandom_range(9) == 0) ? rand_byte() : 8'($urandom_range(1, 3)),
                  subclass, protocol);
        if ((uac2 && $urandom_range(3) != 0) || $urandom_range(7) == 0) add_general();
        add_format(uac2);
        repeat ($urandom_range(2)) add_endpoint();
        if ($urandom_range(3) == 0) begin
          open_desc($urandom_range(2, 30), rand_byte());
          close_desc();
        end
      end
    end
    // Cut the configuration short at a random byte
    if (mode >= 10 && mode < 18) begin
      cut = $urandom_range(1, cfg_q.size() - 1);
      while (cfg_q.size() > cut) void'(cfg_q.pop_back());
    end
  endfunction

  function automatic bit sender_idles();
    if (phase == PH_SEND_IDLE) return $urandom_range(99) < 10;
    if (phase == PH_RECV_IDLE) return $urandom_range(99) < 87;
    return 1'b0;
  endfunction

  // Offer one byte and hold it until the parser takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (sender_idles()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.end_of_config <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_byte(b, last);
    items_sent++;
    if (items_sent < ITEM_GOAL / 3) phase = PH_SEND_IDLE;
    else if (items_sent < 2 * ITEM_GOAL / 3) phase = PH_RECV_IDLE;
    else phase = PH_FREE;
    if (phase == PH_FREE) squeeze_req = 1'b1;
  endtask

  task automatic drive_config();
    int i;
    for (i = 0; i < cfg_q.size(); i++) send_byte(cfg_q[i], i == cfg_q.size() - 1);
  endtask

  // Result side: random stalls per phase, plus one long hold-off
  always @(posedge clk) begin
    if (squeeze_req && !squeeze_done) begin
      squeeze_left = SQUEEZE_CYCLES;
      squeeze_done = 1'b1;
    end
    if (squeeze_left > 0) begin
      squeeze_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (phase)
        PH_SEND_IDLE: out_ch.ready <= ($urandom_range(99) >= 87);
        PH_RECV_IDLE: out_ch.ready <= ($urandom_range(99) >= 10);
        default:      out_ch.ready <= 1'b1;
      endcase
    end
  end

  // Check each accepted result
  always @(posedge clk) begin : take_result
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.entry_kind, out_ch.if_num, out_ch.alt_setting,
             out_ch.ep_addr, out_ch.packet_max, out_ch.channel_count,
             out_ch.subframe_size, out_ch.sample_bits, out_ch.sample_rate,
             out_ch.class_rev, out_ch.found_any, out_ch.run_last};
      board.check_entry(got);
    end
  end

  initial begin
    board = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.byte_value <= 8'h00;
    in_ch.end_of_config <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Lone last byte in a short configuration, at both byte extremes
    cfg_q = {8'h00};
    drive_config();
    cfg_q = {8'hFF};
    drive_config();
    // Length below two halts parsing
    cfg_q = {8'h01};
    repeat (8) put_byte(8'hFF);
    drive_config();
    // Interface descriptor cut off by the last byte
    cfg_q = {8'h0A, DT_INTERFACE, 8'h00, 8'h01, 8'h01, CLASS_AUDIO,
             SUBCLASS_STREAMING, PROTOCOL_UAC2, 8'h00};
    drive_config();

    // Random configurations
    while (items_sent < ITEM_GOAL) begin
      build_config();
      drive_config();
    end
    in_ch.valid <= 1'b0;

    // Drain, then watch for stray results
    while (board.waiting() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.waiting() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
